FILE: rtl/bspa_pkg.sv
package bspa_pkg;

    localparam int MAX_NODES      = 16;
    localparam int MAX_SLOTS      = 256;
    localparam int WORD_W         = 64;
    localparam int WORD_SHIFT     = 6;
    localparam int WORDS_PER_NODE = MAX_SLOTS / WORD_W;
    localparam int POOL_WORDS     = MAX_NODES * WORDS_PER_NODE;
    localparam int POOL_SLOTS     = MAX_NODES * MAX_SLOTS;

    localparam int NODE_W   = $clog2(MAX_NODES);
    localparam int SLOT_W   = $clog2(MAX_SLOTS);
    localparam int WSEL_W   = $clog2(WORDS_PER_NODE);
    localparam int ADDR_W   = $clog2(POOL_WORDS);
    localparam int FILL_W   = $clog2(MAX_SLOTS + 1);
    localparam int TOTAL_W  = 13;
    localparam int OPEN_W   = 5;
    localparam int MODE_W   = 2;
    localparam int STATUS_W = 2;
    localparam int BYTES_W  = 16;
    localparam int OFFSET_W = 24;

    localparam int IN_BITS  = MODE_W + NODE_W + SLOT_W;
    localparam int IN_W     = ((IN_BITS + 7) / 8) * 8;
    localparam int OUT_BITS = STATUS_W + NODE_W + SLOT_W + OFFSET_W + TOTAL_W + OPEN_W;
    localparam int OUT_W    = ((OUT_BITS + 7) / 8) * 8;

    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = BYTES_W;

    localparam logic [CFG_IDX_W-1:0] CFG_SLOTS = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_BYTES = 1'd1;

    localparam logic [MODE_W-1:0] MODE_ALLOC   = 2'd0;
    localparam logic [MODE_W-1:0] MODE_RELEASE = 2'd1;
    localparam logic [MODE_W-1:0] MODE_CLEAR   = 2'd2;

    localparam logic [STATUS_W-1:0] STAT_OK       = 2'd0;
    localparam logic [STATUS_W-1:0] STAT_FULL     = 2'd1;
    localparam logic [STATUS_W-1:0] STAT_NOT_USED = 2'd2;
    localparam logic [STATUS_W-1:0] STAT_RANGE    = 2'd3;

    localparam logic [FILL_W-1:0]  SLOTS_RESET = 9'd64;
    localparam logic [BYTES_W-1:0] BYTES_RESET = 16'd1;

endpackage

FILE: rtl/bspa_ram.sv
module bspa_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 64
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

FILE: rtl/bitmap_slot_pool_allocator.sv
// Sequence: a valid release reads its bitmap word in ST_REL and then answers from ST_OUT; clear
// and unused mode go straight to ST_OUT; allocate walks nodes in ST_NODE and bitmap words in ST_SCAN.
// Throughput: one request at a time; the allocate scan over the bitmap RAM, one
// 64-bit word per cycle through its single read port, sets the rate.
// Reset: synchronous, active low; every bitmap word is marked empty at once,
// fills and total clear, one node open, slots_per_node 64, element_bytes 1.
module bitmap_slot_pool_allocator (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           s_tvalid,
    output logic                           s_tready,
    // mode, node_sel, slot_sel
    input  logic [bspa_pkg::IN_W-1:0]      s_tdata,
    output logic                           m_tvalid,
    input  logic                           m_tready,
    // status, node_out, slot_out, byte_offset, total_count, nodes_open
    output logic [bspa_pkg::OUT_W-1:0]     m_tdata,
    input  logic                           cfg_valid,
    output logic                           cfg_ready,
    input  logic [bspa_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [bspa_pkg::CFG_DATA_W-1:0] cfg_data
);
    import bspa_pkg::*;

    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_NODE = 3'd1;
    localparam logic [2:0] ST_SCAN = 3'd2;
    localparam logic [2:0] ST_REL  = 3'd3;
    localparam logic [2:0] ST_OUT  = 3'd4;

    logic [2:0]           state_reg, state_next;
    logic [NODE_W-1:0]    node_reg, node_next;
    logic [WSEL_W-1:0]    word_reg, word_next;
    logic [SLOT_W-1:0]    slot_reg, slot_next;
    logic [STATUS_W-1:0]  status_reg, status_next;
    logic                 grant_reg, grant_next;
    logic [FILL_W-1:0]    fill_reg [MAX_NODES];
    logic [FILL_W-1:0]    fill_next [MAX_NODES];
    logic [TOTAL_W-1:0]   total_reg, total_next;
    logic [OPEN_W-1:0]    open_reg, open_next;
    logic [POOL_WORDS-1:0] valid_reg, valid_next;
    logic                 rd_valid_reg;
    logic [FILL_W-1:0]    slots_cfg_reg;
    logic [BYTES_W-1:0]   bytes_cfg_reg;
    logic                 m_tvalid_reg, m_tvalid_next;
    logic [OUT_W-1:0]     m_tdata_reg, m_tdata_next;

    logic                 ram_we;
    logic [ADDR_W-1:0]    ram_waddr;
    logic [WORD_W-1:0]    ram_wdata;
    logic [ADDR_W-1:0]    ram_raddr;
    logic [WORD_W-1:0]    ram_rdata;

    logic [FILL_W-1:0]    lim;
    logic [WORD_W-1:0]    word_data;
    logic [WORD_W-1:0]    scan_mask;
    logic [FILL_W-1:0]    word_base;
    logic [FILL_W-1:0]    next_base;
    logic [FILL_W-1:0]    remain;
    logic [WORD_W-1:0]    scan_word;
    logic                 zero_found;
    logic [WORD_SHIFT-1:0] zero_idx;
    logic [MODE_W-1:0]    in_mode;
    logic [NODE_W-1:0]    in_node;
    logic [SLOT_W-1:0]    in_slot;
    logic                 s_accept;
    logic [OFFSET_W-1:0]  offset;
    logic [OPEN_W-1:0]    node_plus;

    bspa_ram #(
        .WIDTH(WORD_W),
        .DEPTH(POOL_WORDS)
    ) u_bitmap (
        .aclk (aclk),
        .we   (ram_we),
        .waddr(ram_waddr),
        .wdata(ram_wdata),
        .raddr(ram_raddr),
        .rdata(ram_rdata)
    );

    assign s_tready  = (state_reg == ST_IDLE);
    assign s_accept  = s_tvalid && s_tready;
    assign cfg_ready = 1'b1;
    assign m_tvalid  = m_tvalid_reg;
    assign m_tdata   = m_tdata_reg;

    assign in_mode = s_tdata[MODE_W-1:0];
    assign in_node = s_tdata[MODE_W+NODE_W-1:MODE_W];
    assign in_slot = s_tdata[MODE_W+NODE_W+SLOT_W-1:MODE_W+NODE_W];

    always_comb begin
        if (slots_cfg_reg == '0) begin
            lim = FILL_W'(1);
        end else if (slots_cfg_reg > FILL_W'(MAX_SLOTS)) begin
            lim = FILL_W'(MAX_SLOTS);
        end else begin
            lim = slots_cfg_reg;
        end
    end

    assign word_data = ram_rdata & {WORD_W{rd_valid_reg}};
    assign word_base = {1'b0, word_reg, {WORD_SHIFT{1'b0}}};
    assign next_base = word_base + FILL_W'(WORD_W);
    assign remain    = lim - word_base;
    assign scan_mask = (remain >= FILL_W'(WORD_W)) ? {WORD_W{1'b1}}
                     : ((WORD_W'(1) << remain[WORD_SHIFT-1:0]) - WORD_W'(1));
    assign scan_word = word_data | ~scan_mask;
    assign node_plus = OPEN_W'(node_reg) + OPEN_W'(1);
    assign offset    = OFFSET_W'(slot_reg) * OFFSET_W'(bytes_cfg_reg);

    always_comb begin
        zero_found = 1'b0;
        zero_idx   = '0;
        for (int i = WORD_W - 1; i >= 0; i--) begin
            if (!scan_word[i]) begin
                zero_found = 1'b1;
                zero_idx   = WORD_SHIFT'(i);
            end
        end
    end

    always_comb begin
        state_next    = state_reg;
        node_next     = node_reg;
        word_next     = word_reg;
        slot_next     = slot_reg;
        status_next   = status_reg;
        grant_next    = grant_reg;
        fill_next     = fill_reg;
        total_next    = total_reg;
        open_next     = open_reg;
        valid_next    = valid_reg;
        m_tvalid_next = m_tvalid_reg && !m_tready;
        m_tdata_next  = m_tdata_reg;
        ram_we        = 1'b0;
        ram_waddr     = {node_reg, word_reg};
        ram_wdata     = word_data;
        ram_raddr     = {node_reg, word_reg};

        case (state_reg)
            ST_IDLE: begin
                if (s_accept) begin
                    node_next   = in_node;
                    slot_next   = in_slot;
                    word_next   = '0;
                    grant_next  = 1'b0;
                    status_next = STAT_OK;
                    case (in_mode)
                        MODE_ALLOC: begin
                            node_next  = '0;
                            state_next = ST_NODE;
                        end
                        MODE_RELEASE: begin
                            if ((OPEN_W'(in_node) >= open_reg)
                                || (FILL_W'(in_slot) >= lim)) begin
                                status_next = STAT_RANGE;
                                state_next  = ST_OUT;
                            end else begin
                                ram_raddr  = {in_node, in_slot[SLOT_W-1:WORD_SHIFT]};
                                state_next = ST_REL;
                            end
                        end
                        MODE_CLEAR: begin
                            valid_next = '0;
                            for (int n = 0; n < MAX_NODES; n++) begin
                                fill_next[n] = '0;
                            end
                            total_next = '0;
                            state_next = ST_OUT;
                        end
                        default: begin
                            state_next = ST_OUT;
                        end
                    endcase
                end
            end
            ST_NODE: begin
                if (fill_reg[node_reg] >= lim) begin
                    if (node_reg == NODE_W'(MAX_NODES - 1)) begin
                        status_next = STAT_FULL;
                        state_next  = ST_OUT;
                    end else begin
                        node_next = node_reg + NODE_W'(1);
                    end
                end else begin
                    word_next  = '0;
                    ram_raddr  = {node_reg, {WSEL_W{1'b0}}};
                    state_next = ST_SCAN;
                end
            end
            ST_SCAN: begin
                if (zero_found) begin
                    ram_we                = 1'b1;
                    ram_wdata             = word_data;
                    ram_wdata[zero_idx]   = 1'b1;
                    valid_next[{node_reg, word_reg}] = 1'b1;
                    fill_next[node_reg]   = fill_reg[node_reg] + FILL_W'(1);
                    total_next            = total_reg + TOTAL_W'(1);
                    if (node_plus > open_reg) begin
                        open_next = node_plus;
                    end
                    slot_next   = {word_reg, zero_idx};
                    grant_next  = 1'b1;
                    status_next = STAT_OK;
                    state_next  = ST_OUT;
                end else if (next_base >= lim) begin
                    if (node_reg == NODE_W'(MAX_NODES - 1)) begin
                        status_next = STAT_FULL;
                        state_next  = ST_OUT;
                    end else begin
                        node_next  = node_reg + NODE_W'(1);
                        state_next = ST_NODE;
                    end
                end else begin
                    word_next = word_reg + WSEL_W'(1);
                    ram_raddr = {node_reg, word_reg + WSEL_W'(1)};
                end
            end
            ST_REL: begin
                ram_waddr = {node_reg, slot_reg[SLOT_W-1:WORD_SHIFT]};
                if (!word_data[slot_reg[WORD_SHIFT-1:0]]) begin
                    status_next = STAT_NOT_USED;
                end else begin
                    ram_we                                = 1'b1;
                    ram_wdata                             = word_data;
                    ram_wdata[slot_reg[WORD_SHIFT-1:0]]   = 1'b0;
                    valid_next[{node_reg, slot_reg[SLOT_W-1:WORD_SHIFT]}] = 1'b1;
                    if (fill_reg[node_reg] != '0) begin
                        fill_next[node_reg] = fill_reg[node_reg] - FILL_W'(1);
                    end
                    if (total_reg != '0) begin
                        total_next = total_reg - TOTAL_W'(1);
                    end
                end
                state_next = ST_OUT;
            end
            ST_OUT: begin
                if (!m_tvalid_reg || m_tready) begin
                    m_tvalid_next = 1'b1;
                    m_tdata_next  = OUT_W'({open_reg, total_reg,
                                            grant_reg ? offset : OFFSET_W'(0),
                                            grant_reg ? slot_reg : SLOT_W'(0),
                                            grant_reg ? node_reg : NODE_W'(0),
                                            status_reg});
                    state_next    = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            total_reg     <= '0;
            open_reg      <= OPEN_W'(1);
            valid_reg     <= '0;
            rd_valid_reg  <= 1'b0;
            slots_cfg_reg <= SLOTS_RESET;
            bytes_cfg_reg <= BYTES_RESET;
            m_tvalid_reg  <= 1'b0;
            for (int n = 0; n < MAX_NODES; n++) begin
                fill_reg[n] <= '0;
            end
        end else begin
            state_reg    <= state_next;
            total_reg    <= total_next;
            open_reg     <= open_next;
            valid_reg    <= valid_next;
            rd_valid_reg <= valid_reg[ram_raddr];
            m_tvalid_reg <= m_tvalid_next;
            fill_reg     <= fill_next;
            if (cfg_valid && cfg_ready) begin
                case (cfg_index)
                    CFG_SLOTS: slots_cfg_reg <= cfg_data[FILL_W-1:0];
                    CFG_BYTES: bytes_cfg_reg <= cfg_data[BYTES_W-1:0];
                    default: begin
                    end
                endcase
            end
        end
    end

    always_ff @(posedge aclk) begin
        node_reg    <= node_next;
        word_reg    <= word_next;
        slot_reg    <= slot_next;
        status_reg  <= status_next;
        grant_reg   <= grant_next;
        m_tdata_reg <= m_tdata_next;
    end

`ifndef ASSERT_OFF
    a_total_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        total_reg <= TOTAL_W'(POOL_SLOTS))
        else $error("allocated total beyond pool size");

    a_open_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        (open_reg >= OPEN_W'(1)) && (open_reg <= OPEN_W'(MAX_NODES)))
        else $error("open node count out of range");

    a_grant_in_limit: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_SCAN) && zero_found |-> (FILL_W'({word_reg, zero_idx}) < lim))
        else $error("granted slot beyond slot limit");

    a_busy_after_accept: assert property (@(posedge aclk) disable iff (!aresetn)
        s_accept |=> (state_reg != ST_IDLE))
        else $error("request accepted without leaving idle");
`endif

endmodule
